### hw/rtl/modem_power_sequencer_assert.svh
// assertion helpers for the modem power sequencer
`ifndef MODEM_POWER_SEQUENCER_ASSERT_SVH
`define MODEM_POWER_SEQUENCER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define MPS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MPS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/mps_pkg.sv
package mps_pkg;

  // operation codes
  localparam logic [2:0] OpTick     = 3'd0;
  localparam logic [2:0] OpShutdown = 3'd1;
  localparam logic [2:0] OpPowerup  = 3'd2;
  localparam logic [2:0] OpBootMode = 3'd3;
  localparam logic [2:0] OpSuspend  = 3'd4;
  localparam logic [2:0] OpResetEdg = 3'd5;
  localparam logic [2:0] OpResync   = 3'd6;
  localparam logic [2:0] OpReboot   = 3'd7;

  // modem status codes
  localparam logic [2:0] StNormal    = 3'd0;
  localparam logic [2:0] StFlash     = 3'd1;
  localparam logic [2:0] StResetting = 3'd2;
  localparam logic [2:0] StOff       = 3'd3;
  localparam logic [2:0] StUndefined = 3'd4;

  // completion codes
  localparam logic [1:0] ResOk        = 2'd0;
  localparam logic [1:0] ResAlreadyUp = 2'd1;
  localparam logic [1:0] ResFailed    = 2'd2;
  localparam logic [1:0] ResBusy      = 2'd3;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgPollAttempts = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgPollInterval = 1'b1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [7:0]  PollAttemptsRst = 8'd10;
  localparam logic [15:0] PollIntervalRst = 16'd400;

  typedef enum logic [2:0] {
    SeqIdle = 3'b001,
    SeqUp   = 3'b010,
    SeqDown = 3'b100
  } seq_e;

  typedef struct packed {
    logic [2:0] op;
    logic       boot_mode_value;
    logic       reset_pin;
    logic       flash_pin;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic       disable_out;
    logic       power_out;
    logic       flash_select_out;
    logic       busy_res;
    logic       done_res;
    logic [1:0] result_code;
    logic       notify;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  poll_attempts;
    logic [15:0] poll_interval;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        boot_in_flash;
    logic        suspended;
    logic        pin_dis;
    logic        pin_pwr;
    logic        pin_fls;
    seq_e        seq;
    logic [7:0]  samples_taken;
    logic [15:0] wait_left;
  } state_t;

  localparam state_t StateRst = '{
    status:        StUndefined,
    boot_in_flash: 1'b0,
    suspended:     1'b0,
    pin_dis:       1'b0,
    pin_pwr:       1'b0,
    pin_fls:       1'b0,
    seq:           SeqIdle,
    samples_taken: 8'd0,
    wait_left:     16'd0
  };

endpackage

### hw/rtl/mps_cfg_regs.sv
module mps_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mps_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [mps_pkg::CfgDataW-1:0]     cfg_data_i,
  output mps_pkg::cfg_t                    cfg_o
);

  mps_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mps_pkg::CfgPollAttempts: cfg_d.poll_attempts = cfg_data_i[7:0];
        mps_pkg::CfgPollInterval: cfg_d.poll_interval = cfg_data_i[15:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.poll_attempts <= mps_pkg::PollAttemptsRst;
      cfg_q.poll_interval <= mps_pkg::PollIntervalRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/mps_step.sv
module mps_step (
  input  mps_pkg::state_t    state_i,
  input  mps_pkg::in_item_t  item_i,
  input  mps_pkg::cfg_t      cfg_i,
  output mps_pkg::state_t    state_o,
  output mps_pkg::out_item_t res_o
);

  mps_pkg::state_t ns;
  logic        busy;
  logic        sample_en;
  logic        finish_en;
  logic        finish_ok;
  logic        hit;
  logic        done;
  logic [1:0]  code;
  logic        note;
  logic [7:0]  eff_attempts;
  logic [15:0] eff_interval;

  assign eff_attempts = (cfg_i.poll_attempts == 8'd0) ? 8'd1 : cfg_i.poll_attempts;
  assign eff_interval = (cfg_i.poll_interval == 16'd0) ? 16'd1 : cfg_i.poll_interval;
  assign busy = (state_i.seq != mps_pkg::SeqIdle);

  always_comb begin
    ns        = state_i;
    sample_en = 1'b0;
    finish_en = 1'b0;
    finish_ok = 1'b0;
    hit       = 1'b0;
    done      = 1'b0;
    code      = mps_pkg::ResOk;
    note      = 1'b0;

    unique case (item_i.op) inside
      mps_pkg::OpTick: begin
        if (busy) begin
          if (state_i.wait_left > 16'd1) begin
            ns.wait_left = state_i.wait_left - 16'd1;
          end else begin
            ns.wait_left = 16'd0;
            if (state_i.samples_taken >= eff_attempts) begin
              finish_en = 1'b1;
            end else begin
              sample_en = 1'b1;
            end
          end
        end
      end
      mps_pkg::OpResetEdg: begin
        if (!state_i.suspended) begin
          ns.status  = mps_pkg::StResetting;
          ns.pin_pwr = 1'b0;
          note       = 1'b1;
        end
      end
      mps_pkg::OpResync: begin
        if (!busy) begin
          ns.boot_in_flash = item_i.flash_pin;
          ns.suspended     = 1'b0;
          if (item_i.reset_pin) begin
            ns.status = item_i.flash_pin ? mps_pkg::StFlash : mps_pkg::StNormal;
          end else begin
            ns.status = mps_pkg::StOff;
          end
        end
      end
      mps_pkg::OpShutdown, mps_pkg::OpReboot: begin
        note = (item_i.op == mps_pkg::OpReboot);
        if (busy) begin
          done = 1'b1;
          code = mps_pkg::ResBusy;
        end else if (state_i.status == mps_pkg::StOff) begin
          done = 1'b1;
        end else begin
          ns.pin_dis       = 1'b0;
          ns.seq           = mps_pkg::SeqDown;
          ns.samples_taken = 8'd0;
          sample_en        = 1'b1;
        end
      end
      mps_pkg::OpPowerup: begin
        if (busy) begin
          done = 1'b1;
          code = mps_pkg::ResBusy;
        end else if (state_i.status == mps_pkg::StNormal ||
                     state_i.status == mps_pkg::StFlash) begin
          done = 1'b1;
          code = mps_pkg::ResAlreadyUp;
        end else begin
          ns.pin_fls       = state_i.boot_in_flash;
          ns.pin_dis       = 1'b1;
          ns.pin_pwr       = 1'b1;
          ns.seq           = mps_pkg::SeqUp;
          ns.samples_taken = 8'd0;
          sample_en        = 1'b1;
        end
      end
      mps_pkg::OpBootMode: begin
        done = 1'b1;
        if (busy) begin
          code = mps_pkg::ResBusy;
        end else begin
          ns.boot_in_flash = item_i.boot_mode_value;
        end
      end
      mps_pkg::OpSuspend: begin
        done = 1'b1;
        if (busy) begin
          code = mps_pkg::ResBusy;
        end else begin
          ns.suspended = 1'b1;
        end
      end
      default: begin
        ns = state_i;
      end
    endcase

    // one reset pin sample: powerup looks for high, shutdown for low
    if (sample_en) begin
      hit = (ns.seq == mps_pkg::SeqUp) ? item_i.reset_pin : !item_i.reset_pin;
      if (ns.samples_taken != 8'hff) begin
        ns.samples_taken = ns.samples_taken + 8'd1;
      end
      if (hit) begin
        finish_en = 1'b1;
        finish_ok = 1'b1;
      end else begin
        ns.wait_left = eff_interval;
      end
    end

    if (finish_en) begin
      if (ns.seq == mps_pkg::SeqUp) begin
        if (finish_ok) begin
          ns.status = ns.boot_in_flash ? mps_pkg::StFlash : mps_pkg::StNormal;
          code      = mps_pkg::ResOk;
        end else begin
          ns.status = mps_pkg::StUndefined;
          code      = mps_pkg::ResFailed;
        end
      end else begin
        ns.pin_pwr = 1'b0;
        ns.status  = mps_pkg::StOff;
        code       = mps_pkg::ResOk;
      end
      ns.seq           = mps_pkg::SeqIdle;
      ns.samples_taken = 8'd0;
      ns.wait_left     = 16'd0;
      done             = 1'b1;
    end
  end

  assign state_o = ns;

  always_comb begin
    res_o.status           = ns.status;
    res_o.disable_out      = ns.pin_dis;
    res_o.power_out        = ns.pin_pwr;
    res_o.flash_select_out = ns.pin_fls;
    res_o.busy_res         = (ns.seq != mps_pkg::SeqIdle);
    res_o.done_res         = done;
    res_o.result_code      = code;
    res_o.notify           = note;
  end

endmodule

### hw/rtl/modem_power_sequencer.sv
// channel   | direction | handshake           | payload
// ----------+-----------+---------------------+---------------------------------
// in        | input     | in_valid_i/stall_o  | in_item_i (op, pins, boot mode)
// out       | output    | out_valid_o/stall_i | out_item_o (status, pins, done)
// cfg       | input     | cfg_valid_i/ready_o | cfg_index_i, cfg_data_i
//
// one request per cycle while out_stall_i is low; a taken request passes the input
// register, then the step logic into the result register.
// the sequencer state updates as a request moves into the result register, so
// the next request always sees the state its predecessor left.
// rst_ni clears the state to undefined status, idle, all pins low.
// out_stall_i holds the result register; the input register then fills and
// in_stall_o rises.
`include "modem_power_sequencer_assert.svh"

module modem_power_sequencer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  mps_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output mps_pkg::out_item_t             out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mps_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [mps_pkg::CfgDataW-1:0]   cfg_data_i
);

  mps_pkg::cfg_t      cfg;
  mps_pkg::state_t    state_q, state_d;
  mps_pkg::in_item_t  in_item_q;
  mps_pkg::out_item_t out_item_q, res;
  logic               in_valid_q;
  logic               out_valid_q;
  logic               out_free;
  logic               fire;

  mps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mps_step u_step (
    .state_i (state_q),
    .item_i  (in_item_q),
    .cfg_i   (cfg),
    .state_o (state_d),
    .res_o   (res)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= mps_pkg::StateRst;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
    if (fire) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // an idle sequencer has no pending wait or sample count; a running one waits
  `MPS_ASSERT_NOW(a_idle_clear, state_q.seq == mps_pkg::SeqIdle, state_q.wait_left == 16'd0 && state_q.samples_taken == 8'd0, "idle sequencer holds a wait or sample count")
  `MPS_ASSERT_NOW(a_busy_waits, state_q.seq != mps_pkg::SeqIdle, state_q.wait_left != 16'd0, "running sequence without a pending wait")
  `MPS_ASSERT_NOW(a_dis_level, state_q.seq != mps_pkg::SeqIdle, state_q.pin_dis == (state_q.seq == mps_pkg::SeqUp), "disable pin disagrees with sequence direction")
  `MPS_ASSERT_NEXT(a_busy_flag, fire, out_valid_q && out_item_q.busy_res == (state_q.seq != mps_pkg::SeqIdle), "result busy flag disagrees with sequencer state")

endmodule

### bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mps_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned IdlePct    = 35;

  class power_seq_checker;
    logic [7:0]  attempts;
    logic [15:0] interval;
    logic [2:0]  status;
    logic        flash_boot;
    logic        susp;
    logic        pin_dis;
    logic        pin_pwr;
    logic        pin_fls;
    seq_e        seq;
    logic [7:0]  samples;
    logic [15:0] wait_cnt;
    out_item_t   pending_outcomes[$];
    int unsigned n_requests;
    int unsigned n_errors;
    int unsigned n_ok;
    int unsigned n_failed;
    int unsigned n_rejected;
    int unsigned n_notify;

    function new();
      attempts   = PollAttemptsRst;
      interval   = PollIntervalRst;
      status     = StUndefined;
      flash_boot = 1'b0;
      susp       = 1'b0;
      pin_dis    = 1'b0;
      pin_pwr    = 1'b0;
      pin_fls    = 1'b0;
      seq        = SeqIdle;
      samples    = '0;
      wait_cnt   = '0;
      n_requests = 0;
      n_errors   = 0;
      n_ok       = 0;
      n_failed   = 0;
      n_rejected = 0;
      n_notify   = 0;
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      if (idx == CfgPollAttempts) attempts = data[7:0];
      else interval = data;
    endfunction

    function void conclude(bit ok, inout bit done, inout logic [1:0] code);
      if (seq == SeqUp) begin
        status = ok ? (flash_boot ? StFlash : StNormal) : StUndefined;
        code   = ok ? ResOk : ResFailed;
      end else begin
        pin_pwr = 1'b0;
        status  = StOff;
        code    = ResOk;
      end
      seq      = SeqIdle;
      samples  = '0;
      wait_cnt = '0;
      done     = 1'b1;
    endfunction

    // powerup waits for the reset line high, shutdown for it low
    function void sample_reset_pin(bit rpin, inout bit done, inout logic [1:0] code);
      bit hit;
      hit = (seq == SeqUp) ? rpin : !rpin;
      if (samples < 8'd255) samples++;
      if (hit) conclude(1'b1, done, code);
      else wait_cnt = (interval == 0) ? 16'd1 : interval;
    endfunction

    function void note_request(in_item_t req);
      out_item_t   want;
      bit          busy;
      bit          done;
      bit          note;
      logic [1:0]  code;
      logic [7:0]  limit;
      busy  = (seq != SeqIdle);
      done  = 1'b0;
      note  = 1'b0;
      code  = ResOk;
      limit = (attempts == 0) ? 8'd1 : attempts;
      n_requests++;
      case (req.op)
        OpTick: begin
          if (busy) begin
            if (wait_cnt > 1) begin
              wait_cnt--;
            end else begin
              wait_cnt = '0;
              if (samples >= limit) conclude(1'b0, done, code);
              else sample_reset_pin(req.reset_pin, done, code);
            end
          end
        end
        OpResetEdg: begin
          if (!susp) begin
            status  = StResetting;
            pin_pwr = 1'b0;
            note    = 1'b1;
          end
        end
        OpResync: begin
          if (!busy) begin
            flash_boot = req.flash_pin;
            susp       = 1'b0;
            if (req.reset_pin) status = req.flash_pin ? StFlash : StNormal;
            else status = StOff;
          end
        end
        default: begin
          if (req.op == OpReboot) note = 1'b1;
          if (busy) begin
            done = 1'b1;
            code = ResBusy;
          end else if (req.op == OpShutdown || req.op == OpReboot) begin
            if (status == StOff) begin
              done = 1'b1;
            end else begin
              pin_dis = 1'b0;
              seq     = SeqDown;
              samples = '0;
              sample_reset_pin(req.reset_pin, done, code);
            end
          end else if (req.op == OpPowerup) begin
            if (status == StNormal || status == StFlash) begin
              done = 1'b1;
              code = ResAlreadyUp;
            end else begin
              pin_fls = flash_boot;
              pin_dis = 1'b1;
              pin_pwr = 1'b1;
              seq     = SeqUp;
              samples = '0;
              sample_reset_pin(req.reset_pin, done, code);
            end
          end else if (req.op == OpBootMode) begin
            flash_boot = req.boot_mode_value;
            done       = 1'b1;
          end else begin
            susp = 1'b1;
            done = 1'b1;
          end
        end
      endcase
      if (done) begin
        if (code == ResFailed) n_failed++;
        else if (code == ResBusy) n_rejected++;
        else n_ok++;
      end
      if (note) n_notify++;
      want.status           = status;
      want.disable_out      = pin_dis;
      want.power_out        = pin_pwr;
      want.flash_select_out = pin_fls;
      want.busy_res         = (seq != SeqIdle);
      want.done_res         = done;
      want.result_code      = code;
      want.notify           = note;
      pending_outcomes.push_back(want);
    endfunction

    function void match_field(string name, logic [2:0] want, logic [2:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        n_errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_outcomes.size() == 0) begin
        $display("%0t: result %h with no request outstanding", $time, got);
        n_errors++;
        return;
      end
      want = pending_outcomes.pop_front();
      match_field("status", want.status, got.status);
      match_field("disable_out", 3'(want.disable_out), 3'(got.disable_out));
      match_field("power_out", 3'(want.power_out), 3'(got.power_out));
      match_field("flash_select_out", 3'(want.flash_select_out),
                  3'(got.flash_select_out));
      match_field("busy_res", 3'(want.busy_res), 3'(got.busy_res));
      match_field("done_res", 3'(want.done_res), 3'(got.done_res));
      match_field("result_code", 3'(want.result_code), 3'(got.result_code));
      match_field("notify", 3'(want.notify), 3'(got.notify));
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  in_item_t           in_item_i;
  logic               out_valid_o;
  logic               out_stall_i;
  out_item_t          out_item_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  bit          calm;
  bit          hold_request;
  int unsigned cycles;
  power_seq_checker sequencer_model = new();

  modem_power_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic send_request(input in_item_t req);
    if (!calm) begin
      while ($urandom_range(99) < IdlePct) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i = 1'b1;
    in_item_i  = req;
    do @(posedge clk_i); while (in_stall_o);
    sequencer_model.note_request(req);
    @(negedge clk_i);
  endtask

  task automatic send_op(input logic [2:0] op, input bit bval, input bit rpin, input bit fpin);
    in_item_t req;
    req.op              = op;
    req.boot_mode_value = bval;
    req.reset_pin       = rpin;
    req.flash_pin       = fpin;
    send_request(req);
  endtask

  task automatic wait_until_quiet();
    in_valid_i = 1'b0;
    while (sequencer_model.pending_outcomes.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx,
                                input logic [CfgDataW-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sequencer_model.write_register(idx, data);
    @(negedge clk_i);
  endtask

  task automatic program_registers(input logic [CfgDataW-1:0] att,
                                   input logic [CfgDataW-1:0] ivl);
    wait_until_quiet();
    write_register(CfgPollAttempts, att);
    write_register(CfgPollInterval, ivl);
    cfg_valid_i = 1'b0;
  endtask

  task automatic run_random(input int count, input int tick_pct, input int high_pct,
                            input int hold_at, input int pause_at);
    in_item_t req;
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_request = 1'b1;
      if (i == pause_at) wait_until_quiet();
      // ticks dominate so that sequences run to their end
      if ($urandom_range(99) < tick_pct) req.op = OpTick;
      else req.op = 3'($urandom_range(OpReboot, OpShutdown));
      req.boot_mode_value = 1'($urandom_range(1));
      req.reset_pin       = ($urandom_range(99) < high_pct);
      req.flash_pin       = 1'($urandom_range(1));
      send_request(req);
    end
  endtask

  // result side: random stall, or one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall_i  = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
      end
      out_stall_i = !calm && ($urandom_range(99) < IdlePct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) sequencer_model.check_result(out_item_o);
    if (cycles > CycleLimit) begin
      $display("%0t: no progress after %0d cycles", $time, cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_item_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    calm         = 1'b0;
    hold_request = 1'b0;
    cycles       = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // zero in either register behaves as one
    program_registers('0, '0);
    send_op(OpTick, 1'b0, 1'b0, 1'b0);
    send_op(OpPowerup, 1'b0, 1'b1, 1'b0);
    send_op(OpPowerup, 1'b0, 1'b1, 1'b0);
    send_op(OpBootMode, 1'b1, 1'b0, 1'b0);
    send_op(OpShutdown, 1'b0, 1'b1, 1'b0);
    // powerup, reboot, suspend and boot mode bounce off a running shutdown; a reset edge still acts
    send_op(OpPowerup, 1'b0, 1'b1, 1'b1);
    send_op(OpReboot, 1'b0, 1'b0, 1'b0);
    send_op(OpSuspend, 1'b0, 1'b0, 1'b0);
    send_op(OpBootMode, 1'b0, 1'b1, 1'b1);
    send_op(OpResync, 1'b1, 1'b1, 1'b1);
    send_op(OpResetEdg, 1'b0, 1'b0, 1'b0);
    send_op(OpTick, 1'b0, 1'b1, 1'b0);
    send_op(OpShutdown, 1'b0, 1'b0, 1'b0);
    send_op(OpReboot, 1'b1, 1'b1, 1'b1);
    // flash boot powerup that never sees the reset line rise
    send_op(OpPowerup, 1'b0, 1'b0, 1'b0);
    send_op(OpTick, 1'b1, 1'b0, 1'b1);
    send_op(OpSuspend, 1'b1, 1'b1, 1'b1);
    send_op(OpResetEdg, 1'b1, 1'b1, 1'b1);
    send_op(OpResync, 1'b0, 1'b1, 1'b1);
    send_op(OpResync, 1'b0, 1'b0, 1'b0);
    send_op(OpResync, 1'b0, 1'b1, 1'b0);
    send_op(OpReboot, 1'b0, 1'b0, 1'b0);
    send_op(OpPowerup, 1'b0, 1'b1, 1'b0);
    send_op(OpResetEdg, 1'b0, 1'b1, 1'b0);

    // upper data bits are ignored for the attempts register
    program_registers({8'($urandom), 8'd3}, 16'd2);
    run_random(200, 50, 50, 100, 160);

    calm = 1'b1;
    program_registers(16'd1, 16'd1);
    run_random(150, 45, 30, -1, -1);

    // full attempt count with the reset line almost always low
    calm = 1'b0;
    program_registers(16'd255, 16'd1);
    run_random(800, 85, 1, -1, -1);

    program_registers(16'd5, 16'hffff);
    run_random(150, 60, 50, 40, -1);

    wait_until_quiet();
    repeat (6) @(posedge clk_i);
    $display("%0d requests across five register settings, zero through full scale",
             sequencer_model.n_requests);
    $display("%0d ok completions, %0d start failures, %0d busy rejects, %0d notify events",
             sequencer_model.n_ok, sequencer_model.n_failed,
             sequencer_model.n_rejected, sequencer_model.n_notify);
    if (sequencer_model.n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/mps_pkg.sv
hw/rtl/mps_cfg_regs.sv
hw/rtl/mps_step.sv
hw/rtl/modem_power_sequencer.sv
bench/tb.sv
